// ===== rtl/blr_pkg.sv =====
package blr_pkg;

  // Fixed field widths of the command and pixel words.
  localparam int unsigned CoordW = 12;
  localparam int unsigned ColorW = 32;
  localparam int unsigned AddrW  = 19;
  localparam int unsigned DecW   = 16;

  // Default screen size.
  localparam int unsigned ScreenWidthDef  = 640;
  localparam int unsigned ScreenHeightDef = 480;

  // Command codes.
  typedef enum logic [0:0] {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  // Running line state kept between words.
  typedef struct packed {
    logic                     busy;
    logic                     x_major;
    logic signed [CoordW-1:0] cur_major;
    logic signed [CoordW-1:0] cur_minor;
    logic signed [CoordW-1:0] end_major;
    logic signed [DecW-1:0]   decision;
    logic signed [DecW-1:0]   step_small;
    logic signed [DecW-1:0]   step_large;
    logic                     minor_down;
    logic [ColorW-1:0]        color;
  } line_t;

  // One result word.
  typedef struct packed {
    logic                     produced;
    logic                     write_enable;
    logic [AddrW-1:0]         pixel_address;
    logic [ColorW-1:0]        pixel_color;
    logic signed [CoordW-1:0] pixel_x;
    logic signed [CoordW-1:0] pixel_y;
    logic                     last_pixel;
  } pixel_t;

endpackage

// ===== rtl/blr_if.sv =====
// Command channel: one word starts a line or asks for its next pixel.
interface blr_cmd_if
  import blr_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [0:0]               command;
  logic signed [CoordW-1:0] start_x;
  logic signed [CoordW-1:0] start_y;
  logic signed [CoordW-1:0] end_x;
  logic signed [CoordW-1:0] end_y;
  logic [ColorW-1:0]        line_color;

  modport source (
    output valid, command, start_x, start_y, end_x, end_y, line_color,
    input  ready
  );
  modport sink (
    input  valid, command, start_x, start_y, end_x, end_y, line_color,
    output ready
  );
endinterface

// Pixel channel: one word per accepted command.
interface blr_pix_if
  import blr_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     produced;
  logic                     write_enable;
  logic [AddrW-1:0]         pixel_address;
  logic [ColorW-1:0]        pixel_color;
  logic signed [CoordW-1:0] pixel_x;
  logic signed [CoordW-1:0] pixel_y;
  logic                     last_pixel;

  modport source (
    output valid, produced, write_enable, pixel_address, pixel_color, pixel_x,
           pixel_y, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, produced, write_enable, pixel_address, pixel_color, pixel_x,
           pixel_y, last_pixel,
    output ready
  );
endinterface

// ===== rtl/blr_setup.sv =====
module blr_setup
  import blr_pkg::*;
(
  input  logic signed [CoordW-1:0] start_x_i,
  input  logic signed [CoordW-1:0] start_y_i,
  input  logic signed [CoordW-1:0] end_x_i,
  input  logic signed [CoordW-1:0] end_y_i,
  input  logic [ColorW-1:0]        color_i,
  output line_t                    line_o
);

  logic signed [CoordW:0]   dx, dy;
  logic [CoordW:0]          w, h, dmaj, dmin;
  logic                     x_major;
  logic signed [CoordW-1:0] sma, smi, ema, emi;
  logic                     swap;
  logic signed [DecW-1:0]   dmaj_s, dmin_s;

  // Width and height of the line, one bit wider than a coordinate.
  always_comb begin
    dx = {end_x_i[CoordW-1], end_x_i} - {start_x_i[CoordW-1], start_x_i};
    dy = {end_y_i[CoordW-1], end_y_i} - {start_y_i[CoordW-1], start_y_i};
    w  = dx[CoordW] ? -dx : dx;
    h  = dy[CoordW] ? -dy : dy;
    x_major = (h <= w);
  end

  // Pick the major axis and order the endpoints so the major coordinate rises.
  always_comb begin
    if (x_major) begin
      sma = start_x_i; smi = start_y_i; ema = end_x_i; emi = end_y_i;
      dmaj = w; dmin = h;
    end else begin
      sma = start_y_i; smi = start_x_i; ema = end_y_i; emi = end_x_i;
      dmaj = h; dmin = w;
    end
    swap = (ema < sma);
  end

  // Load the decision terms and the first pixel position.
  always_comb begin
    dmaj_s = $signed(DecW'(dmaj));
    dmin_s = $signed(DecW'(dmin));
    line_o.x_major    = x_major;
    line_o.cur_major  = swap ? ema : sma;
    line_o.cur_minor  = swap ? emi : smi;
    line_o.end_major  = swap ? sma : ema;
    line_o.minor_down = swap ? (smi < emi) : (emi < smi);
    line_o.step_small = dmin_s <<< 1;
    line_o.step_large = (dmin_s - dmaj_s) <<< 1;
    line_o.decision   = (dmin_s <<< 1) - dmaj_s;
    line_o.busy       = (sma != ema);
    line_o.color      = color_i;
  end

endmodule

// ===== rtl/blr_address.sv =====
module blr_address
  import blr_pkg::*;
#(
  parameter int unsigned ScreenWidth  = ScreenWidthDef,
  parameter int unsigned ScreenHeight = ScreenHeightDef
) (
  input  logic signed [CoordW-1:0] x_i,
  input  logic signed [CoordW-1:0] y_i,
  output logic                     on_screen_o,
  output logic [AddrW-1:0]         addr_o
);

  // Screen coordinates need two bits beyond a pixel coordinate.
  localparam int unsigned ScrW = CoordW + 2;
  localparam logic signed [ScrW-1:0] HalfW  = ScrW'(ScreenWidth / 2);
  localparam logic signed [ScrW-1:0] HalfH  = ScrW'(ScreenHeight / 2);
  localparam logic signed [ScrW-1:0] LimW   = ScrW'(ScreenWidth);
  localparam logic signed [ScrW-1:0] LimH   = ScrW'(ScreenHeight);
  localparam logic [ScrW-2:0]        WidthC = (ScrW-1)'(ScreenWidth);

  logic signed [ScrW-1:0]  col, row;
  logic [2*(ScrW-1)-1:0]   prod, sum;

  // Centered, y-up coordinates to column and row.
  always_comb begin
    col = HalfW + ScrW'(x_i);
    row = HalfH - ScrW'(y_i);
    on_screen_o = (col >= 0) && (col < LimW) && (row >= 0) && (row < LimH);
  end

  // Row-major word offset; constant multiplier plus one add.
  always_comb begin
    prod   = row[ScrW-2:0] * WidthC;
    sum    = prod + (2*(ScrW-1))'(col[ScrW-2:0]);
    addr_o = on_screen_o ? sum[AddrW-1:0] : '0;
  end

endmodule

// ===== rtl/bresenham_line_rasterizer.sv =====
// Bresenham line rasterizer.
// Commands arrive on cmd_i (valid/ready). A start word loads both endpoints
// and a color and yields the line's first pixel; each step word yields the
// next pixel, advancing the major coordinate by one. Every accepted word
// gives exactly one word on pix_o: coordinates, color, frame-buffer address
// (row-major, screen-centered, y up), an on-screen write enable and a mark
// on the endpoint. A step word while no line is active gives an all-zero
// word with produced low.
// pix_o.valid rises in the cycle after a word is accepted. One word is taken
// every cycle while pix_o is not stalled: the line state is updated in the
// accepting cycle by one decision add and an increment, and the address
// costs one constant multiply and add ahead of the output register.
// When the receiver stalls, the output register holds its word and
// cmd_i.ready drops until that word is taken; it rises again in the same
// cycle the word leaves, so no bubble appears.
// Reset clears the line state and the output valid; the block is idle.
module bresenham_line_rasterizer
  import blr_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = ScreenWidthDef,
  parameter int unsigned SCREEN_HEIGHT = ScreenHeightDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  blr_cmd_if.sink   cmd_i,
  blr_pix_if.source pix_o
);

  line_t  line_q, line_d, start_line, step_line;
  pixel_t pix_q, pix_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   is_start;
  logic signed [CoordW-1:0] px, py;
  logic   on_screen;
  logic [AddrW-1:0] addr;

  assign cmd_i.ready = !out_valid_q || pix_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign is_start    = (cmd_i.command == CMD_START);

  // Line setup from the start word.
  blr_setup u_setup (
    .start_x_i (cmd_i.start_x),
    .start_y_i (cmd_i.start_y),
    .end_x_i   (cmd_i.end_x),
    .end_y_i   (cmd_i.end_y),
    .color_i   (cmd_i.line_color),
    .line_o    (start_line)
  );

  // One Bresenham step on the running line.
  always_comb begin
    step_line = line_q;
    step_line.cur_major = line_q.cur_major + CoordW'(1);
    if (line_q.decision < 0) begin
      step_line.decision = line_q.decision + line_q.step_small;
    end else begin
      step_line.decision  = line_q.decision + line_q.step_large;
      step_line.cur_minor = line_q.minor_down ? line_q.cur_minor - CoordW'(1)
                                              : line_q.cur_minor + CoordW'(1);
    end
    step_line.busy = (step_line.cur_major != line_q.end_major);
  end

  // Next line state: a start always loads, a step moves only a busy line.
  always_comb begin
    line_d = line_q;
    if (accept) begin
      if (is_start) begin
        line_d = start_line;
      end else if (line_q.busy) begin
        line_d = step_line;
      end
    end
  end

  // Pixel position from the new state.
  assign px = line_d.x_major ? line_d.cur_major : line_d.cur_minor;
  assign py = line_d.x_major ? line_d.cur_minor : line_d.cur_major;

  blr_address #(
    .ScreenWidth  (SCREEN_WIDTH),
    .ScreenHeight (SCREEN_HEIGHT)
  ) u_address (
    .x_i         (px),
    .y_i         (py),
    .on_screen_o (on_screen),
    .addr_o      (addr)
  );

  // Result word; an idle step gives all zeros.
  always_comb begin
    pix_d = '0;
    if (is_start || line_q.busy) begin
      pix_d.produced      = 1'b1;
      pix_d.write_enable  = on_screen;
      pix_d.pixel_address = addr;
      pix_d.pixel_color   = line_d.color;
      pix_d.pixel_x       = px;
      pix_d.pixel_y       = py;
      pix_d.last_pixel    = !line_d.busy;
    end
  end

  // Output valid follows accepts and drains on ready.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (pix_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      line_q      <= line_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o.valid         = out_valid_q;
  assign pix_o.produced      = pix_q.produced;
  assign pix_o.write_enable  = pix_q.write_enable;
  assign pix_o.pixel_address = pix_q.pixel_address;
  assign pix_o.pixel_color   = pix_q.pixel_color;
  assign pix_o.pixel_x       = pix_q.pixel_x;
  assign pix_o.pixel_y       = pix_q.pixel_y;
  assign pix_o.last_pixel    = pix_q.last_pixel;

endmodule

// ===== rtl/blr_checker.sv =====
module blr_checker
  import blr_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cmd_valid_i,
  input logic             cmd_ready_i,
  input logic [0:0]       cmd_command_i,
  input logic             pix_valid_i,
  input logic             pix_ready_i,
  input logic             pix_produced_i,
  input logic             pix_write_enable_i,
  input logic [AddrW-1:0] pix_address_i,
  input logic             pix_last_i
);

  // Every accepted command word shows up as an output word next cycle.
  a_accept_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> pix_valid_i)
    else $error("accepted command gave no output word");

  // A start word always yields a pixel.
  a_start_produces: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i && (cmd_command_i == CMD_START)
      |=> pix_valid_i && pix_produced_i)
    else $error("start command gave no pixel");

  // A word without a pixel carries nothing else.
  a_idle_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && !pix_produced_i
      |-> !pix_write_enable_i && !pix_last_i && (pix_address_i == '0))
    else $error("idle step word is not all zero");

  // Off-screen pixels carry address zero.
  a_offscreen_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && !pix_write_enable_i |-> (pix_address_i == '0))
    else $error("off-screen pixel has nonzero address");

  // A stalled output word stays valid.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && !pix_ready_i |=> pix_valid_i)
    else $error("output word dropped while stalled");

endmodule

bind bresenham_line_rasterizer blr_checker u_blr_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .cmd_valid_i        (cmd_i.valid),
  .cmd_ready_i        (cmd_i.ready),
  .cmd_command_i      (cmd_i.command),
  .pix_valid_i        (pix_o.valid),
  .pix_ready_i        (pix_o.ready),
  .pix_produced_i     (pix_o.produced),
  .pix_write_enable_i (pix_o.write_enable),
  .pix_address_i      (pix_o.pixel_address),
  .pix_last_i         (pix_o.last_pixel)
);
